// File: src/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the polyline direction snap block:
// configuration register indexes and reset values, the direction selector
// codes, and the command group passed from controller to datapath.
// ----------------------------------------------------------------------------
package pds_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SNAP_LIMIT = 3'd0;
    localparam logic [2:0] CFG_DIR_COUNT  = 3'd1;
    localparam logic [2:0] CFG_DIR_A_X    = 3'd2;
    localparam logic [2:0] CFG_DIR_A_Z    = 3'd3;
    localparam logic [2:0] CFG_DIR_B_X    = 3'd4;
    localparam logic [2:0] CFG_DIR_B_Z    = 3'd5;
    localparam logic [2:0] CFG_DIR_C_X    = 3'd6;
    localparam logic [2:0] CFG_DIR_C_Z    = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Configuration reset values
    localparam logic [30:0]        SNAP_LIMIT_RST = 31'd0;
    localparam logic [1:0]         DIR_COUNT_RST  = 2'd2;
    localparam logic signed [15:0] DIR_ONE        = 16'sd16384;
    localparam logic signed [15:0] DIR_ZERO       = 16'sd0;

    // Direction selector codes
    localparam logic [1:0] DIR_A = 2'd0;
    localparam logic [1:0] DIR_B = 2'd1;
    localparam logic [1:0] DIR_C = 2'd2;

    // Point payload widths
    localparam int COORD_W = 32;
    localparam int POINT_W = 2 * COORD_W;

    // Configuration register file contents
    typedef struct packed {
        logic [30:0]        snap_limit;
        logic [1:0]         dir_count;
        logic signed [15:0] dir_a_x;
        logic signed [15:0] dir_a_z;
        logic signed [15:0] dir_b_x;
        logic signed [15:0] dir_b_z;
        logic signed [15:0] dir_c_x;
        logic signed [15:0] dir_c_z;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_wr;     // write incoming point into the store
        logic       load_first;  // capture incoming point as the first point
        logic       seg_start;   // start point of the walk is the first point
        logic       rd_en;       // read the store
        logic       end_first;   // segment end point comes from the first point
        logic       diff;        // latch end point and segment difference
        logic       dir_mul;     // multiply difference by one direction
        logic       dir_acc;     // sum products and keep the best direction
        logic       dir_first;   // first direction of the search
        logic [1:0] dir_sel;     // direction under test
        logic       proj;        // round the best dot product
        logic       move;        // multiply projection by the normal
        logic       round;       // round the move components
        logic       abs_chk;     // component limit check and squares
        logic       limit;       // squared length limit check
        logic       update;      // write back the end point
        logic       out_load;    // load the output register from the store
    } cmd_t;

endpackage

// File: src/pds_ram.sv
// ----------------------------------------------------------------------------
// pds_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pds_datapath.sv
// ----------------------------------------------------------------------------
// pds_datapath
// Point store and segment arithmetic: segment difference, direction search
// by smallest absolute dot product, projection, move, limit checks and the
// clamped write-back of the moved end point. Also holds the output data.
// ----------------------------------------------------------------------------
module pds_datapath
    import pds_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  cfg_t                          cfg,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    input  logic [COORD_W-1:0]            in_x,
    input  logic [COORD_W-1:0]            in_z,
    output logic                          zero_seg,
    output logic [COORD_W-1:0]            out_x,
    output logic [COORD_W-1:0]            out_z
);

    // Store
    logic               ram_we;
    logic [POINT_W-1:0] ram_wdata;
    logic [POINT_W-1:0] ram_rdata;

    // Segment registers
    logic [31:0] first_x_reg, first_z_reg;
    logic [31:0] cur_x_reg, cur_z_reg;
    logic [31:0] end_x_reg, end_z_reg;
    logic [32:0] dx_reg, dz_reg;

    // Direction search
    logic signed [15:0] dir_x_sel, dir_z_sel;
    logic signed [48:0] px_reg, pz_reg;
    logic [49:0]        dot;
    logic [49:0]        mag;
    logic               better;
    logic [49:0]        best_dot_reg;
    logic [49:0]        best_mag_reg;
    logic signed [15:0] best_nx_reg, best_nz_reg;

    // Projection and move
    logic [50:0]        proj_sum;
    logic signed [36:0] proj_reg;
    logic signed [15:0] nx_reg, nz_reg;
    logic signed [52:0] mxp_reg, mzp_reg;
    logic [53:0]        mx_sum, mz_sum;
    logic [39:0]        mx_reg, mz_reg;
    logic [39:0]        amx, amz;
    logic [61:0]        sqx_reg, sqz_reg, lsq_reg;
    logic               abs_ok_reg;
    logic               move_ok_reg;

    // Write-back
    logic [40:0] nx_full, nz_full;
    logic [31:0] clamp_x, clamp_z;
    logic        apply;
    logic [31:0] new_x, new_z;
    logic [31:0] end_x, end_z;

    logic [31:0] out_x_reg, out_z_reg;

    pds_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Select the direction under test
    always_comb
    begin
        case (cmd.dir_sel)
            DIR_A:
            begin
                dir_x_sel = cfg.dir_a_x;
                dir_z_sel = cfg.dir_a_z;
            end
            DIR_B:
            begin
                dir_x_sel = cfg.dir_b_x;
                dir_z_sel = cfg.dir_b_z;
            end
            default:
            begin
                dir_x_sel = cfg.dir_c_x;
                dir_z_sel = cfg.dir_c_z;
            end
        endcase
    end

    // Segment end point comes from the store or, on the closing segment, the first point
    assign end_x = cmd.end_first ? first_x_reg : ram_rdata[31:0];
    assign end_z = cmd.end_first ? first_z_reg : ram_rdata[63:32];

    assign zero_seg = (dx_reg == 33'd0) && (dz_reg == 33'd0);

    // Dot product and its magnitude
    assign dot    = {px_reg[48], px_reg} + {pz_reg[48], pz_reg};
    assign mag    = dot[49] ? (50'd0 - dot) : dot;
    assign better = mag < best_mag_reg;

    // Round half up, then floor shift by 14
    assign proj_sum = {best_dot_reg[49], best_dot_reg} + 51'd8192;
    assign mx_sum   = {mxp_reg[52], mxp_reg} + 54'd8192;
    assign mz_sum   = {mzp_reg[52], mzp_reg} + 54'd8192;

    assign amx = mx_reg[39] ? (40'd0 - mx_reg) : mx_reg;
    assign amz = mz_reg[39] ? (40'd0 - mz_reg) : mz_reg;

    // Move the end point and clamp to the coordinate range
    assign nx_full = {{9{end_x_reg[31]}}, end_x_reg} - {mx_reg[39], mx_reg};
    assign nz_full = {{9{end_z_reg[31]}}, end_z_reg} - {mz_reg[39], mz_reg};

    always_comb
    begin
        if (nx_full[40:31] == 10'h000 || nx_full[40:31] == 10'h3FF)
        begin
            clamp_x = nx_full[31:0];
        end
        else
        begin
            clamp_x = nx_full[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (nz_full[40:31] == 10'h000 || nz_full[40:31] == 10'h3FF)
        begin
            clamp_z = nz_full[31:0];
        end
        else
        begin
            clamp_z = nz_full[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    assign apply = move_ok_reg && !zero_seg;
    assign new_x = apply ? clamp_x : end_x_reg;
    assign new_z = apply ? clamp_z : end_z_reg;

    // Store write: incoming point or updated end point
    assign ram_we    = cmd.load_wr || cmd.update;
    assign ram_wdata = cmd.update ? {new_z, new_x} : {in_z, in_x};

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            first_x_reg <= in_x;
            first_z_reg <= in_z;
        end

        if (cmd.seg_start)
        begin
            cur_x_reg <= first_x_reg;
            cur_z_reg <= first_z_reg;
        end
        else if (cmd.update)
        begin
            cur_x_reg <= new_x;
            cur_z_reg <= new_z;
        end

        if (cmd.diff)
        begin
            end_x_reg <= end_x;
            end_z_reg <= end_z;
            dx_reg    <= {end_x[31], end_x} - {cur_x_reg[31], cur_x_reg};
            dz_reg    <= {end_z[31], end_z} - {cur_z_reg[31], cur_z_reg};
        end

        if (cmd.dir_mul)
        begin
            px_reg <= $signed(dx_reg) * dir_x_sel;
            pz_reg <= $signed(dz_reg) * dir_z_sel;
        end

        // Keep the direction with the smallest magnitude, lowest index on a tie
        if (cmd.dir_acc && (cmd.dir_first || better))
        begin
            best_dot_reg <= dot;
            best_mag_reg <= mag;
            best_nx_reg  <= dir_x_sel;
            best_nz_reg  <= dir_z_sel;
        end

        if (cmd.proj)
        begin
            proj_reg <= $signed(proj_sum[50:14]);
            nx_reg   <= best_nx_reg;
            nz_reg   <= best_nz_reg;
        end

        if (cmd.move)
        begin
            mxp_reg <= proj_reg * nx_reg;
            mzp_reg <= proj_reg * nz_reg;
        end

        if (cmd.round)
        begin
            mx_reg <= mx_sum[53:14];
            mz_reg <= mz_sum[53:14];
        end

        // Squares are only meaningful once both components pass the limit
        if (cmd.abs_chk)
        begin
            abs_ok_reg <= (amx <= {9'd0, cfg.snap_limit}) && (amz <= {9'd0, cfg.snap_limit});
            sqx_reg    <= amx[30:0] * amx[30:0];
            sqz_reg    <= amz[30:0] * amz[30:0];
            lsq_reg    <= cfg.snap_limit * cfg.snap_limit;
        end

        if (cmd.limit)
        begin
            move_ok_reg <= abs_ok_reg && (({1'b0, sqx_reg} + {1'b0, sqz_reg}) <= {1'b0, lsq_reg});
        end

        if (cmd.out_load)
        begin
            out_x_reg <= ram_rdata[31:0];
            out_z_reg <= ram_rdata[63:32];
        end
    end

    assign out_x = out_x_reg;
    assign out_z = out_z_reg;

endmodule

// File: src/pds_ctrl.sv
// ----------------------------------------------------------------------------
// pds_ctrl
// Controller: loads points, walks the segments and the directions, steps the
// datapath through each segment, then emits the stored points in order.
// ----------------------------------------------------------------------------
module pds_ctrl
    import pds_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    dir_count,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_tlast,
    input  logic                          zero_seg,
    output cmd_t                          cmd,
    output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0] wr_addr
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [13:0] {
        ST_LOAD      = 14'b00_0000_0000_0001,
        ST_SEG_RD    = 14'b00_0000_0000_0010,
        ST_SEG_DIFF  = 14'b00_0000_0000_0100,
        ST_DIR_MUL   = 14'b00_0000_0000_1000,
        ST_DIR_ACC   = 14'b00_0000_0001_0000,
        ST_PROJ      = 14'b00_0000_0010_0000,
        ST_MOVE      = 14'b00_0000_0100_0000,
        ST_ROUND     = 14'b00_0000_1000_0000,
        ST_ABS       = 14'b00_0001_0000_0000,
        ST_LIMIT     = 14'b00_0010_0000_0000,
        ST_UPDATE    = 14'b00_0100_0000_0000,
        ST_EMIT_RD   = 14'b00_1000_0000_0000,
        ST_EMIT_LD   = 14'b01_0000_0000_0000,
        ST_EMIT_WAIT = 14'b10_0000_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] e_reg, e_next;
    logic [1:0]       k_reg, k_next;
    logic             wrap_reg, wrap_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;

    logic             in_xfer;
    logic             full;
    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] e_inc;
    logic [1:0]       dir_eff;
    logic [1:0]       k_inc;

    assign in_xfer = s_tvalid && (state_reg == ST_LOAD);
    assign full    = (count_reg == MAX_CNT);
    assign j_inc   = j_reg + CNT_ONE;
    assign e_inc   = e_reg + CNT_ONE;
    assign dir_eff = (dir_count == 2'd0) ? 2'd1 : dir_count;
    assign k_inc   = k_reg + 2'd1;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;
        cmd.dir_sel    = k_reg;
        rd_addr        = j_inc[ADDR_W-1:0];
        wr_addr        = count_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                // Store points until the last one, drop them once full
                if (in_xfer)
                begin
                    cmd.load_wr    = !full;
                    cmd.load_first = (count_reg == '0);
                    if (!full)
                    begin
                        count_next = count_reg + CNT_ONE;
                    end
                    if (s_tlast)
                    begin
                        n_next     = full ? count_reg : count_reg + CNT_ONE;
                        count_next = '0;
                        j_next     = '0;
                        state_next = ST_SEG_RD;
                    end
                end
            end
            ST_SEG_RD:
            begin
                cmd.rd_en     = 1'b1;
                cmd.seg_start = (j_reg == '0);
                wrap_next     = (j_inc == n_reg);
                state_next    = ST_SEG_DIFF;
            end
            ST_SEG_DIFF:
            begin
                cmd.diff      = 1'b1;
                cmd.end_first = wrap_reg;
                k_next        = DIR_A;
                state_next    = ST_DIR_MUL;
            end
            ST_DIR_MUL:
            begin
                // Skip a zero-length segment
                if (zero_seg)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.dir_mul = 1'b1;
                    state_next  = ST_DIR_ACC;
                end
            end
            ST_DIR_ACC:
            begin
                cmd.dir_acc   = 1'b1;
                cmd.dir_first = (k_reg == DIR_A);
                if (k_inc >= dir_eff)
                begin
                    state_next = ST_PROJ;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ST_DIR_MUL;
                end
            end
            ST_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_chk = 1'b1;
                state_next  = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Write back the end point, wrap to the first point last
                cmd.update = 1'b1;
                wr_addr    = wrap_reg ? '0 : j_inc[ADDR_W-1:0];
                if (wrap_reg)
                begin
                    e_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = ST_SEG_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = e_reg[ADDR_W-1:0];
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                out_last_next  = (e_inc == n_reg);
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                // Hold the point until the transfer completes
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        e_next     = e_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            e_reg         <= '0;
            k_reg         <= DIR_A;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            e_reg         <= e_next;
            k_reg         <= k_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: src/polyline_direction_snap.sv
// ----------------------------------------------------------------------------
// polyline_direction_snap
// Loads a closed polyline, snaps each segment onto the main direction whose
// normal it is closest to, within a move limit, then emits all points.
//
//   channel  dir  signals                              payload
//   s_*      in   s_tvalid s_tready s_tdata s_tlast    point x, z; last point
//   m_*      out  m_tvalid m_tready m_tdata m_tlast    adjusted x, z; last
//   cfg_*    in   cfg_we cfg_addr cfg_wdata            register writes
//
// Points load one per cycle. Then the controller steps each segment
// through the datapath, with a multiply and accumulate step per direction
// (a zero-length segment skips to write-back); each point then leaves via
// a store read and an output load, held while the output stalls. Input is
// not taken during the walk and the emission. Reset clears control state
// and the configuration registers; the point store needs no clearing.
// ----------------------------------------------------------------------------
module polyline_direction_snap
    import pds_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Input points
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,    // [31:0] point_x_in, [63:32] point_z_in
    input  logic                   s_tlast,    // final_point
    // Output points
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,    // [31:0] point_x_out, [63:32] point_z_out
    output logic                   m_tlast,    // end_of_run
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_POINTS);

    cfg_t              cfg_reg;
    cmd_t              cmd;
    logic              zero_seg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       out_x;
    logic [31:0]       out_z;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.snap_limit <= SNAP_LIMIT_RST;
            cfg_reg.dir_count  <= DIR_COUNT_RST;
            cfg_reg.dir_a_x    <= DIR_ONE;
            cfg_reg.dir_a_z    <= DIR_ZERO;
            cfg_reg.dir_b_x    <= DIR_ZERO;
            cfg_reg.dir_b_z    <= DIR_ONE;
            cfg_reg.dir_c_x    <= DIR_ZERO;
            cfg_reg.dir_c_z    <= DIR_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SNAP_LIMIT: cfg_reg.snap_limit <= cfg_wdata;
                CFG_DIR_COUNT:  cfg_reg.dir_count  <= cfg_wdata[1:0];
                CFG_DIR_A_X:    cfg_reg.dir_a_x    <= cfg_wdata[15:0];
                CFG_DIR_A_Z:    cfg_reg.dir_a_z    <= cfg_wdata[15:0];
                CFG_DIR_B_X:    cfg_reg.dir_b_x    <= cfg_wdata[15:0];
                CFG_DIR_B_Z:    cfg_reg.dir_b_z    <= cfg_wdata[15:0];
                CFG_DIR_C_X:    cfg_reg.dir_c_x    <= cfg_wdata[15:0];
                CFG_DIR_C_Z:    cfg_reg.dir_c_z    <= cfg_wdata[15:0];
                default:        cfg_reg.dir_c_z    <= cfg_reg.dir_c_z;
            endcase
        end
    end

    pds_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir_count (cfg_reg.dir_count),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .zero_seg  (zero_seg),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    pds_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk      (clk),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .in_x     (s_tdata[31:0]),
        .in_z     (s_tdata[63:32]),
        .zero_seg (zero_seg),
        .out_x    (out_x),
        .out_z    (out_z)
    );

    assign m_tdata = {out_z, out_x};

endmodule

// File: bench/polyline_direction_snap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_direction_snap_tb
// Self-checking bench for the polyline direction snap block. Points stream in
// as closed polylines. A scoreboard keeps its own copy of the registers and
// the point store, snaps every segment the way the block should, and checks
// each emitted point field by field. A directed part covers extreme
// coordinates, zero-length and tied segments, the limit checks and a zero
// direction count. Random polylines follow across several register settings,
// with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module polyline_direction_snap_tb;
    import pds_pkg::*;

    localparam int     STORE_DEPTH   = 64;
    localparam int     CLK_PERIOD    = 10;
    localparam int     IDLE_PCT      = 23;
    localparam int     RANDOM_POINTS = 230;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     PRINT_LIMIT   = 100;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam longint COORD_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
        logic        last;
    } snap_point_t;

    typedef enum {SHAPE_TRACE, SHAPE_NOISE, SHAPE_REPEAT} shape_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, point store and the queue of awaited points
    // ------------------------------------------------------------------------
    class snap_scoreboard;
        logic [30:0] snap_limit;
        logic [1:0]  dir_count;
        int          dir_x [3];
        int          dir_z [3];
        int          x_pts [STORE_DEPTH];
        int          z_pts [STORE_DEPTH];
        int unsigned loaded;
        snap_point_t awaited_points [$];
        int          errors;
        int unsigned checked;

        function new();
            snap_limit = SNAP_LIMIT_RST;
            dir_count  = DIR_COUNT_RST;
            dir_x[0] = DIR_ONE;  dir_z[0] = DIR_ZERO;
            dir_x[1] = DIR_ZERO; dir_z[1] = DIR_ONE;
            dir_x[2] = DIR_ZERO; dir_z[2] = DIR_ZERO;
            loaded  = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [30:0] val);
            logic signed [15:0] comp;
            comp = val[15:0];
            case (idx)
                CFG_SNAP_LIMIT: snap_limit = val;
                CFG_DIR_COUNT:  dir_count  = val[1:0];
                CFG_DIR_A_X:    dir_x[0]   = comp;
                CFG_DIR_A_Z:    dir_z[0]   = comp;
                CFG_DIR_B_X:    dir_x[1]   = comp;
                CFG_DIR_B_Z:    dir_z[1]   = comp;
                CFG_DIR_C_X:    dir_x[2]   = comp;
                CFG_DIR_C_Z:    dir_z[2]   = comp;
                default: ;
            endcase
        endfunction

        // Round half up, then drop the 14 fraction bits of a direction
        function longint round_q14(longint v);
            return (v + 64'sd8192) >>> 14;
        endfunction

        // Move the segment end point along the best normal, in place
        function void snap_segment(int unsigned i0, int unsigned i1);
            longint      dx, dz, dot, mag, best_mag, proj, mx, mz, lim, x1, z1;
            int unsigned cnt, k, best;
            dx = longint'(x_pts[i1]) - longint'(x_pts[i0]);
            dz = longint'(z_pts[i1]) - longint'(z_pts[i0]);
            if (dx == 0 && dz == 0)
                return;
            // a zero count still searches one direction
            cnt = (dir_count == 2'd0) ? 1 : dir_count;
            best = 0;
            best_mag = 0;
            for (k = 0; k < cnt; k++)
            begin
                dot = dx * dir_x[k] + dz * dir_z[k];
                mag = (dot < 0) ? -dot : dot;
                if (k == 0 || mag < best_mag)
                begin
                    best_mag = mag;
                    best = k;
                end
            end
            proj = round_q14(dx * dir_x[best] + dz * dir_z[best]);
            mx   = round_q14(proj * dir_x[best]);
            mz   = round_q14(proj * dir_z[best]);
            lim  = snap_limit;
            // drop moves beyond the limit, per component and as a length
            if (((mx < 0) ? -mx : mx) > lim || ((mz < 0) ? -mz : mz) > lim)
                return;
            if (mx * mx + mz * mz > lim * lim)
                return;
            x1 = longint'(x_pts[i1]) - mx;
            z1 = longint'(z_pts[i1]) - mz;
            if (x1 > COORD_MAX) x1 = COORD_MAX;
            if (x1 < COORD_MIN) x1 = COORD_MIN;
            if (z1 > COORD_MAX) z1 = COORD_MAX;
            if (z1 < COORD_MIN) z1 = COORD_MIN;
            x_pts[i1] = int'(x1);
            z_pts[i1] = int'(z1);
        endfunction

        // Store an accepted point; the final one runs the walk
        function void note_point(logic [31:0] x, logic [31:0] z, logic last);
            int unsigned j;
            snap_point_t p;
            if (loaded < STORE_DEPTH)
            begin
                x_pts[loaded] = x;
                z_pts[loaded] = z;
                loaded++;
            end
            if (!last)
                return;
            for (j = 0; j < loaded; j++)
                snap_segment(j, (j + 1 == loaded) ? 0 : j + 1);
            for (j = 0; j < loaded; j++)
            begin
                p.x    = x_pts[j];
                p.z    = z_pts[j];
                p.last = (j + 1 == loaded);
                awaited_points = {awaited_points, p};
            end
            loaded = 0;
        endfunction

        function int pending();
            return awaited_points.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_point(logic [31:0] x, logic [31:0] z, logic last);
            snap_point_t want;
            if (awaited_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected point x=%h z=%h last=%b", x, z, last));
                return;
            end
            want = awaited_points.pop_front();
            if (x !== want.x)
                report_mismatch($sformatf("point %0d x got %h want %h", checked, x, want.x));
            if (z !== want.z)
                report_mismatch($sformatf("point %0d z got %h want %h", checked, z, want.z));
            if (last !== want.last)
                report_mismatch($sformatf("point %0d last got %b want %b",
                                          checked, last, want.last));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [63:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    snap_scoreboard sb;
    bit             steady = 1'b0;
    int unsigned    points_sent = 0;
    int unsigned    cycle_count = 0;

    polyline_direction_snap #(
        .MAX_POINTS(STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the output side at random, except in the steady stretch
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_point(m_tdata[31:0], m_tdata[63:32], m_tlast);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("polyline_direction_snap test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_point(input int x, input int z, input bit last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, x};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_point(x, z, last);
        points_sent++;
    endtask

    // Hold input until every awaited point is out and the block is quiet
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [30:0] dir_word(input int v);
        return {15'b0, v[15:0]};
    endfunction

    task automatic apply_config(input logic [30:0] limit, input logic [1:0] count,
                                input int ax, input int az, input int bx, input int bz,
                                input int cx, input int cz);
        drain_results();
        write_register(CFG_SNAP_LIMIT, limit);
        write_register(CFG_DIR_COUNT, {29'b0, count});
        write_register(CFG_DIR_A_X, dir_word(ax));
        write_register(CFG_DIR_A_Z, dir_word(az));
        write_register(CFG_DIR_B_X, dir_word(bx));
        write_register(CFG_DIR_B_Z, dir_word(bz));
        write_register(CFG_DIR_C_X, dir_word(cx));
        write_register(CFG_DIR_C_Z, dir_word(cz));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_direction(output int px, output int pz);
        case ($urandom_range(9))
            0: begin px = 16384;  pz = 0;      end
            1: begin px = 0;      pz = 16384;  end
            2: begin px = -16384; pz = 0;      end
            3: begin px = 0;      pz = -16384; end
            4: begin px = 11585;  pz = 11585;  end
            5: begin px = -11585; pz = 11585;  end
            6: begin px = 14189;  pz = 8192;   end
            7: begin px = -8192;  pz = 14189;  end
            default:
            begin
                px = int'($urandom_range(32768)) - 16384;
                pz = int'($urandom_range(32768)) - 16384;
            end
        endcase
    endtask

    task automatic random_config();
        logic [30:0] limit;
        logic [1:0]  count;
        int          d [6];
        int          k;
        case ($urandom_range(4))
            0: limit = '0;
            1: limit = 31'h7FFF_FFFF;
            2: limit = 31'($urandom());
            default: limit = 31'(1) << $urandom_range(8, 22);
        endcase
        count = ($urandom_range(7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        for (k = 0; k < 3; k++)
            pick_direction(d[2 * k], d[2 * k + 1]);
        apply_config(limit, count, d[0], d[1], d[2], d[3], d[4], d[5]);
    endtask

    // One closed polyline: traced along the main directions with small
    // sideways error, fully random, or with repeated points
    task automatic send_polyline(input int len, input shape_t style);
        longint px, pz, step, amp;
        int     j, k, cnt;
        cnt = (sb.dir_count == 2'd0) ? 1 : sb.dir_count;
        amp = longint'(1) << $urandom_range(0, 18);
        px  = longint'($urandom_range(32'h2000_0000)) - 64'sh1000_0000;
        pz  = longint'($urandom_range(32'h2000_0000)) - 64'sh1000_0000;
        for (j = 0; j < len; j++)
        begin
            case (style)
                SHAPE_TRACE:
                begin
                    if (j > 0)
                    begin
                        k    = $urandom_range(cnt - 1);
                        step = longint'($urandom_range(1, 1 << 20));
                        if ($urandom_range(1))
                            step = -step;
                        px = px + ((step * sb.dir_x[k]) >>> 14)
                                + longint'($urandom_range(2 * amp)) - amp;
                        pz = pz + ((step * sb.dir_z[k]) >>> 14)
                                + longint'($urandom_range(2 * amp)) - amp;
                    end
                end
                SHAPE_NOISE:
                begin
                    px = longint'(int'($urandom()));
                    pz = longint'(int'($urandom()));
                end
                default:
                begin
                    if (j == 0 || $urandom_range(1))
                    begin
                        px = longint'($urandom_range(1 << 18)) - (1 << 17);
                        pz = longint'($urandom_range(1 << 18)) - (1 << 17);
                    end
                end
            endcase
            send_point(int'(px), int'(pz), j == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int          poly;
        int          len;
        int unsigned start_count;
        int          roll;
        shape_t      style;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single point under reset registers, extreme coordinates
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        // open limit, three directions with a diagonal third
        apply_config(31'h7FFF_FFFF, 2'd3, 16384, 0, 0, 16384, -16384, 16384);
        send_point(0, 0, 1'b0);
        send_point(32'h000A_0003, 32'h0000_0007, 1'b0);
        send_point(32'h000A_0011, 32'h0008_0000, 1'b0);
        send_point(32'hFFFF_FFF9, 32'h0008_0002, 1'b1);
        // corners of the coordinate range, pushed to clamping
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(0, 1, 1'b1);
        // zero-length segment, then a tie between the axes
        send_point(32'h0000_0064, 32'h0000_0064, 1'b0);
        send_point(32'h0000_0064, 32'h0000_0064, 1'b0);
        send_point(32'h0001_0064, 32'h0001_0064, 1'b1);

        // zero direction count: one direction only, tight limit
        apply_config(31'h0002_0000, 2'd0, 16384, 0, 0, 16384, 0, 0);
        send_point(0, 0, 1'b0);
        send_point(32'h0001_0000, 32'h0050_0000, 1'b0);
        send_point(32'h0004_0000, 0, 1'b1);

        // diagonal normal: components pass, squared length fails first
        apply_config(31'h0002_0000, 2'd1, 11585, 11585, 0, 16384, 0, 0);
        send_point(0, 0, 1'b0);
        send_point(32'h0003_0000, 0, 1'b0);
        send_point(32'h0003_0000, 32'h0002_8000, 1'b1);

        // zero limit: exact moves only
        apply_config(31'h0, 2'd2, 16384, 0, 0, 16384, 0, 0);
        send_point(0, 0, 1'b0);
        send_point(32'h0001_0000, 0, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_point(1, 32'h0001_0000, 1'b1);

        // random polylines over changing settings
        start_count = points_sent;
        poly = 0;
        while (points_sent - start_count < RANDOM_POINTS)
        begin
            if (poly % 4 == 0)
                random_config();
            else if ($urandom_range(9) == 0)
                drain_results();
            steady = (poly >= 10 && poly < 18);
            if (poly == 5)
                len = STORE_DEPTH + 6;
            else if ($urandom_range(9) == 0)
                len = 1;
            else
                len = $urandom_range(2, 9);
            roll = $urandom_range(99);
            if (roll < 70)
                style = SHAPE_TRACE;
            else if (roll < 85)
                style = SHAPE_NOISE;
            else
                style = SHAPE_REPEAT;
            send_polyline(len, style);
            poly++;
        end
        steady = 1'b0;

        drain_results();
        if (sb.errors == 0)
            $display("polyline_direction_snap test passed");
        else
            $display("polyline_direction_snap test failed");
        $finish;
    end

endmodule
